// ===== design/tpwm_pkg.sv =====
// shared constants, register map and types for the timer register block
package tpwm_pkg;

    localparam int CHANNELS = 4;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [11:0] OFF_VERSION = 12'h000;
    localparam logic [11:0] OFF_PARAM   = 12'h004;
    localparam logic [11:0] OFF_GLOBAL  = 12'h008;
    localparam logic [11:0] OFF_SC      = 12'h010;
    localparam logic [11:0] OFF_CNT     = 12'h014;
    localparam logic [11:0] OFF_MOD     = 12'h018;
    localparam logic [11:0] OFF_CH0     = 12'h020;

    localparam logic [31:0] VERSION_VALUE = 32'h0600_0007;
    localparam logic [31:0] MOD_DEFAULT   = 32'h0000_ffff;
    localparam logic [31:0] PARAM_VALUE   = {8'd0, 8'd32, 8'd4, 8'(CHANNELS)};

    localparam int GLOBAL_RESET_BIT = 1;
    localparam int MODE_HI = 4;
    localparam int MODE_LO = 3;
    localparam int PS_HI   = 2;

    typedef struct packed {
        logic       tick_en;
        logic       restart;
        logic [2:0] ps;
    } tpwm_cnt_ctrl_t;

endpackage

// ===== design/timer_pwm_register_block.sv =====
// timer register block: register map, bus decode and read word register
//
// one input word per cycle on operation/offset/write_data, taken when
// in_valid is high and in_stall is low. a read (operation 0) returns one
// read_data word on out_valid in the cycle after it is taken; writes and
// ticks (1, 2) return nothing, code 3 is dropped. state updates at the
// accepting edge, so the next word sees it with no gap: one word per cycle
// sustained while in_stall is low. the only storage in the path is the read
// word register; in_stall follows out_stall only while a read word
// waits in it. a tick while counting (mode bits nonzero, clock_present
// high) advances the prescaler and, when it rolls over, the counter, which
// wraps to 0 past the modulo; count logic is one 32-bit add and compare.
// clock_present is written on cfg_valid/cfg_data (cfg_ready is always high);
// the user must write it only while no word is in flight (not enforced).
// reset (rst_n low, async) restores all register defaults, sets
// clock_present and empties the read word register.
module timer_pwm_register_block
    import tpwm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [11:0] offset,
    input  logic [31:0] write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    logic        clock_present_reg;
    logic [31:0] sc_reg, sc_next;
    logic [31:0] modulo_reg, modulo_next;
    logic [31:0] ch_ctrl_reg [CHANNELS];
    logic [31:0] ch_ctrl_next [CHANNELS];
    logic [31:0] ch_cmp_reg [CHANNELS];
    logic [31:0] ch_cmp_next [CHANNELS];
    logic        out_valid_reg, out_valid_next;
    logic [31:0] read_data_reg, read_data_next;

    logic                in_accept;
    logic                is_read;
    logic                is_write;
    logic                counting;
    logic [11:0]         ch_rel;
    logic                ch_hit;
    logic [CH_IDX_W-1:0] ch_idx;
    logic                global_reset;
    logic [31:0]         count;
    tpwm_cnt_ctrl_t      cnt_ctrl;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign is_read   = in_accept && (operation == OP_READ);
    assign is_write  = in_accept && (operation == OP_WRITE);
    assign counting  = (sc_reg[MODE_HI:MODE_LO] != 2'd0) && clock_present_reg;
    assign cfg_ready = 1'b1;

    // channel window: low two offset bits ignored
    assign ch_rel = offset - OFF_CH0;
    assign ch_hit = (offset >= OFF_CH0) && (ch_rel[11:3] < 9'(CHANNELS));
    assign ch_idx = ch_rel[3 +: CH_IDX_W];

    assign global_reset = is_write && (offset == OFF_GLOBAL)
                          && write_data[GLOBAL_RESET_BIT];

    always_comb
    begin
        cnt_ctrl.ps      = sc_reg[PS_HI:0];
        cnt_ctrl.tick_en = in_accept && (operation == OP_TICK) && counting;
        cnt_ctrl.restart = global_reset
                           || (is_write && (offset == OFF_CNT))
                           || (is_write && (offset == OFF_SC)
                               && (write_data[MODE_HI:MODE_LO] != 2'd0)
                               && (sc_reg[MODE_HI:MODE_LO] == 2'd0));
    end

    tpwm_counter u_counter (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (cnt_ctrl),
        .modulo (modulo_reg),
        .count  (count)
    );

    // register writes
    always_comb
    begin
        sc_next     = sc_reg;
        modulo_next = modulo_reg;
        for (int i = 0; i < CHANNELS; i++)
        begin
            ch_ctrl_next[i] = ch_ctrl_reg[i];
            ch_cmp_next[i]  = ch_cmp_reg[i];
        end
        if (global_reset)
        begin
            sc_next     = '0;
            modulo_next = MOD_DEFAULT;
            for (int i = 0; i < CHANNELS; i++)
            begin
                ch_ctrl_next[i] = '0;
                ch_cmp_next[i]  = '0;
            end
        end
        else if (is_write)
        begin
            if (offset == OFF_SC)
            begin
                sc_next = write_data;
            end
            else if (offset == OFF_MOD)
            begin
                modulo_next = write_data;
            end
            else if (ch_hit)
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (ch_idx == CH_IDX_W'(i))
                    begin
                        if (ch_rel[2])
                            ch_cmp_next[i] = write_data;
                        else
                            ch_ctrl_next[i] = write_data;
                    end
                end
            end
        end
    end

    // read decode
    always_comb
    begin
        read_data_next = read_data_reg;
        out_valid_next = out_valid_reg;
        if (is_read)
        begin
            out_valid_next = 1'b1;
            unique case (offset)
                OFF_VERSION: read_data_next = VERSION_VALUE;
                OFF_PARAM:   read_data_next = PARAM_VALUE;
                OFF_SC:      read_data_next = sc_reg;
                OFF_CNT:     read_data_next = counting ? count : 32'd0;
                OFF_MOD:     read_data_next = modulo_reg;
                default:
                begin
                    if (ch_hit)
                        read_data_next = ch_rel[2] ? ch_cmp_reg[ch_idx]
                                                   : ch_ctrl_reg[ch_idx];
                    else
                        read_data_next = 32'd0;
                end
            endcase
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_present_reg <= 1'b1;
            sc_reg            <= '0;
            modulo_reg        <= MOD_DEFAULT;
            out_valid_reg     <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                ch_ctrl_reg[i] <= '0;
                ch_cmp_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                clock_present_reg <= cfg_data;
            sc_reg        <= sc_next;
            modulo_reg    <= modulo_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < CHANNELS; i++)
            begin
                ch_ctrl_reg[i] <= ch_ctrl_next[i];
                ch_cmp_reg[i]  <= ch_cmp_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        read_data_reg <= read_data_next;
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

    a_read_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        is_read |=> out_valid_reg)
        else $error("accepted read produced no word");

    a_no_spurious_word: assert property (@(posedge clk) disable iff (!rst_n)
        (!is_read && (!out_valid_reg || !out_stall)) |=> !out_valid_reg)
        else $error("read word appeared without a read");

    a_global_defaults: assert property (@(posedge clk) disable iff (!rst_n)
        global_reset |=> (modulo_reg == MOD_DEFAULT) && (sc_reg == 32'd0))
        else $error("global reset write did not restore defaults");

endmodule

// ===== design/tpwm_counter.sv =====
// prescaler and modulo counter
module tpwm_counter
    import tpwm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  tpwm_cnt_ctrl_t ctrl,
    input  logic [31:0]    modulo,
    output logic [31:0]    count
);

    logic [6:0]  prescale_reg;
    logic [6:0]  prescale_next;
    logic [31:0] count_reg;
    logic [31:0] count_next;
    logic [7:0]  divide;
    logic [7:0]  prescale_inc;

    always_comb
    begin
        divide        = 8'd1 << ctrl.ps;
        prescale_inc  = {1'b0, prescale_reg} + 8'd1;
        prescale_next = prescale_reg;
        count_next    = count_reg;
        if (ctrl.restart)
        begin
            prescale_next = '0;
            count_next    = '0;
        end
        else if (ctrl.tick_en)
        begin
            if (prescale_inc >= divide)
            begin
                prescale_next = '0;
                // a count above a lowered modulo wraps here too
                count_next = (count_reg >= modulo) ? 32'd0 : count_reg + 32'd1;
            end
            else
            begin
                prescale_next = prescale_inc[6:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= '0;
            count_reg    <= '0;
        end
        else
        begin
            prescale_reg <= prescale_next;
            count_reg    <= count_next;
        end
    end

    assign count = count_reg;

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.restart |=> (count_reg == 32'd0) && (prescale_reg == 7'd0))
        else $error("counter not cleared after restart");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.tick_en || ctrl.restart) |=> $stable(count_reg) && $stable(prescale_reg))
        else $error("counter moved without tick or restart");

endmodule
